// File: hw/rtl/lrukc_pkg.sv
package lrukc_pkg;

  localparam int PAGE_W = 14;
  localparam int NUM_PAGES_DEF = 16384;
  localparam int CAPACITY_DEF = 64;

  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_DUMP_HIST = 2'd1;
  localparam logic [1:0] OP_DUMP_CACHE = 2'd2;

  localparam logic [1:0] MEM_NONE = 2'd0;
  localparam logic [1:0] MEM_HIST = 2'd1;
  localparam logic [1:0] MEM_CACHE = 2'd2;

  localparam logic [1:0] HW_NEW = 2'd0;
  localparam logic [1:0] HW_HIST = 2'd1;
  localparam logic [1:0] HW_CACHE = 2'd2;

  localparam logic REG_HIT_THRESHOLD = 1'b0;
  localparam logic REG_QUEUE_LIMIT = 1'b1;

  localparam logic [7:0] THR_RESET = 8'd2;
  localparam logic [6:0] LIMIT_RESET = 7'd16;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [1:0] op;
    logic [PAGE_W-1:0] page;
  } in_t;

  typedef struct packed {
    logic [1:0] hit_where;
    logic promoted;
    logic evict_valid;
    logic evict_queue;
    logic [PAGE_W-1:0] evicted_page;
    logic [PAGE_W-1:0] listed_page;
    logic list_empty;
    logic last;
  } out_t;

  typedef struct packed {
    logic [1:0] member;
    logic [7:0] count;
  } meta_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_DEC, ST_EV_RD1, ST_EV_RD2, ST_EV_WR,
    ST_AP_RD, ST_AP_W1, ST_AP_W2, ST_RES, ST_D_RD, ST_D_OUT
  } state_t;

endpackage

// File: hw/rtl/lru_k_two_queue_cache_unit.sv
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    in_data (in_t: op, page)
// out_     output     out_valid / out_ready  out_data (out_t)
// cfg_     input      cfg_we                 cfg_idx, cfg_wdata
//
// An access takes a read of the page's metadata and links, an unlink, an
// optional head eviction (two dependent next-link reads and a write) and an
// append (a tail prev-link read and two writes), all serialized on the link memories.
// A dump gives its items one at a time, one next-link memory read per entry.
// After reset a clearing pass over the NUM_PAGES + 4 link nodes sets the membership
// memory and the list sentinels; no item is accepted during it.
// Items are taken one at a time; a result waits in the output register while
// the next item is taken.
module lru_k_two_queue_cache_unit
  import lrukc_pkg::*;
#(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_idx,
  input  logic [7:0] cfg_wdata
);

  localparam int LW = $clog2(NUM_PAGES + 4);
  localparam int PW = $clog2(NUM_PAGES);
  localparam int NODES = NUM_PAGES + 4;
  localparam logic [LW-1:0] HH = LW'(NUM_PAGES);
  localparam logic [LW-1:0] CH = LW'(NUM_PAGES + 1);
  localparam logic [LW-1:0] HT = LW'(NUM_PAGES + 2);
  localparam logic [LW-1:0] CT = LW'(NUM_PAGES + 3);
  localparam logic [LW-1:0] LAST_NODE = LW'(NUM_PAGES + 3);
  localparam logic [6:0] CAP7 = 7'(CAPACITY);

  meta_t meta_mem [NUM_PAGES];
  logic [LW-1:0] next_mem [NODES];
  logic [LW-1:0] prev_mem [NODES];

  logic meta_we, meta_re, next_we, next_re, prev_we, prev_re;
  logic [PW-1:0] meta_wa, meta_ra;
  meta_t meta_wd, meta_rd_r;
  logic [LW-1:0] next_wa, next_ra, next_wd, next_rd_r;
  logic [LW-1:0] prev_wa, prev_ra, prev_wd, prev_rd_r;

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (meta_re) meta_rd_r <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd_r <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_rd_r <= prev_mem[prev_ra];
  end

  state_t state_r, state_nxt;
  logic [LW-1:0] clr_idx_r, clr_idx_nxt;
  logic [7:0] thr_r;
  logic [6:0] qlim_r, lim;
  logic [6:0] hsize_r, hsize_nxt, csize_r, csize_nxt;
  logic [LW-1:0] page_r, page_nxt, tail_r, tail_nxt, head_r, head_nxt;
  logic [LW-1:0] x_r, x_nxt, cur_r, cur_nxt;
  logic [1:0] mem_r, mem_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [6:0] idx_r, idx_nxt, dsize_r, dsize_nxt;
  out_t res_r, res_nxt;
  logic out_valid_r, out_load;
  out_t out_data_r, out_d;

  logic out_free, accept, in_range, is_dump, dump_empty, ev_h, ev_c, promote, d_last;
  logic [7:0] inc_cnt;
  logic [6:0] dump_size;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  assign lim = (qlim_r == 7'd0) ? 7'd1 : ((qlim_r > CAP7) ? CAP7 : qlim_r);
  assign in_range = 32'(in_data.page) < NUM_PAGES;
  assign is_dump = (in_data.op == OP_DUMP_HIST) || (in_data.op == OP_DUMP_CACHE);
  assign dump_size = (in_data.op == OP_DUMP_HIST) ? hsize_r : csize_r;
  assign dump_empty = (dump_size == 7'd0);
  assign ev_h = (hsize_r >= lim) && (hsize_r != 7'd0);
  assign ev_c = (csize_r >= lim) && (csize_r != 7'd0);
  assign inc_cnt = (meta_rd_r.count == COUNT_MAX) ? COUNT_MAX : meta_rd_r.count + 8'd1;
  assign promote = inc_cnt >= thr_r;
  assign d_last = (7'(idx_r + 7'd1) == dsize_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: if (clr_idx_r == LAST_NODE) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_ACCESS && in_range) state_nxt = ST_DEC;
          else if (is_dump && !dump_empty) state_nxt = ST_D_RD;
          else state_nxt = ST_RES;
        end
      end
      ST_DEC: begin
        case (meta_rd_r.member)
          MEM_NONE: state_nxt = ev_h ? ST_EV_RD1 : ST_AP_RD;
          MEM_HIST: state_nxt = (promote && ev_c) ? ST_EV_RD1 : ST_AP_RD;
          default: state_nxt = ST_AP_RD;
        endcase
      end
      ST_EV_RD1: state_nxt = ST_EV_RD2;
      ST_EV_RD2: state_nxt = ST_EV_WR;
      ST_EV_WR: state_nxt = ST_AP_RD;
      ST_AP_RD: state_nxt = ST_AP_W1;
      ST_AP_W1: state_nxt = ST_AP_W2;
      ST_AP_W2: state_nxt = ST_RES;
      ST_RES: if (out_free) state_nxt = ST_IDLE;
      ST_D_RD: state_nxt = ST_D_OUT;
      ST_D_OUT: if (out_free) state_nxt = d_last ? ST_IDLE : ST_D_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory controls and datapath.
  always_comb begin
    meta_we = 1'b0; meta_re = 1'b0; meta_wa = '0; meta_ra = '0; meta_wd = '0;
    next_we = 1'b0; next_re = 1'b0; next_wa = '0; next_ra = '0; next_wd = '0;
    prev_we = 1'b0; prev_re = 1'b0; prev_wa = '0; prev_ra = '0; prev_wd = '0;
    clr_idx_nxt = clr_idx_r;
    hsize_nxt = hsize_r; csize_nxt = csize_r;
    page_nxt = page_r; tail_nxt = tail_r; head_nxt = head_r;
    x_nxt = x_r; cur_nxt = cur_r; mem_nxt = mem_r; cnt_nxt = cnt_r;
    idx_nxt = idx_r; dsize_nxt = dsize_r; res_nxt = res_r;
    out_load = 1'b0; out_d = res_r;
    case (state_r)
      ST_CLR: begin
        clr_idx_nxt = clr_idx_r + LW'(1);
        meta_we = (clr_idx_r < HH);
        meta_wa = PW'(clr_idx_r);
        next_we = 1'b1; next_wa = clr_idx_r;
        next_wd = (clr_idx_r == HH) ? HT : ((clr_idx_r == CH) ? CT : '0);
        prev_we = 1'b1; prev_wa = clr_idx_r;
        prev_wd = (clr_idx_r == HT) ? HH : ((clr_idx_r == CT) ? CH : '0);
      end
      ST_IDLE: begin
        if (accept) begin
          page_nxt = LW'(in_data.page);
          meta_re = 1'b1; meta_ra = PW'(in_data.page);
          next_re = 1'b1; next_ra = LW'(in_data.page);
          prev_re = 1'b1; prev_ra = LW'(in_data.page);
          res_nxt = '0;
          res_nxt.last = 1'b1;
          res_nxt.list_empty = is_dump && dump_empty;
          cur_nxt = (in_data.op == OP_DUMP_HIST) ? HH : CH;
          dsize_nxt = dump_size;
          idx_nxt = 7'd0;
        end
      end
      ST_DEC: begin
        if (meta_rd_r.member != MEM_NONE) begin
          // Unlink the page from whichever list holds it.
          next_we = 1'b1; next_wa = prev_rd_r; next_wd = next_rd_r;
          prev_we = 1'b1; prev_wa = next_rd_r; prev_wd = prev_rd_r;
        end
        case (meta_rd_r.member)
          MEM_NONE: begin
            res_nxt.hit_where = HW_NEW;
            mem_nxt = MEM_HIST; cnt_nxt = 8'd1; tail_nxt = HT; head_nxt = HH;
          end
          MEM_HIST: begin
            res_nxt.hit_where = HW_HIST;
            if (promote) begin
              res_nxt.promoted = 1'b1;
              mem_nxt = MEM_CACHE; cnt_nxt = 8'd0; tail_nxt = CT; head_nxt = CH;
              if (hsize_r != 7'd0) hsize_nxt = hsize_r - 7'd1;
            end else begin
              mem_nxt = MEM_HIST; cnt_nxt = inc_cnt; tail_nxt = HT;
            end
          end
          default: begin
            res_nxt.hit_where = HW_CACHE;
            mem_nxt = MEM_CACHE; cnt_nxt = meta_rd_r.count; tail_nxt = CT;
          end
        endcase
      end
      ST_EV_RD1: begin
        next_re = 1'b1; next_ra = head_r;
      end
      ST_EV_RD2: begin
        x_nxt = next_rd_r;
        next_re = 1'b1; next_ra = next_rd_r;
      end
      ST_EV_WR: begin
        next_we = 1'b1; next_wa = head_r; next_wd = next_rd_r;
        prev_we = 1'b1; prev_wa = next_rd_r; prev_wd = head_r;
        meta_we = (x_r < HH); meta_wa = PW'(x_r);
        res_nxt.evict_valid = 1'b1;
        res_nxt.evict_queue = (head_r == CH);
        res_nxt.evicted_page = PAGE_W'(x_r);
        if (head_r == CH) csize_nxt = csize_r - 7'd1;
        else hsize_nxt = hsize_r - 7'd1;
      end
      ST_AP_RD: begin
        prev_re = 1'b1; prev_ra = tail_r;
      end
      ST_AP_W1: begin
        prev_we = 1'b1; prev_wa = page_r; prev_wd = prev_rd_r;
        next_we = 1'b1; next_wa = prev_rd_r; next_wd = page_r;
        meta_we = 1'b1; meta_wa = PW'(page_r);
        meta_wd.member = mem_r; meta_wd.count = cnt_r;
      end
      ST_AP_W2: begin
        prev_we = 1'b1; prev_wa = tail_r; prev_wd = page_r;
        next_we = 1'b1; next_wa = page_r; next_wd = tail_r;
        if (res_r.hit_where == HW_NEW) hsize_nxt = hsize_r + 7'd1;
        if (res_r.promoted) csize_nxt = csize_r + 7'd1;
      end
      ST_RES: begin
        out_load = out_free;
      end
      ST_D_RD: begin
        next_re = 1'b1; next_ra = cur_r;
      end
      ST_D_OUT: begin
        out_d = '0;
        out_d.listed_page = PAGE_W'(next_rd_r);
        out_d.last = d_last;
        if (out_free) begin
          out_load = 1'b1;
          cur_nxt = next_rd_r;
          idx_nxt = idx_r + 7'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_idx_r <= '0;
      thr_r <= THR_RESET;
      qlim_r <= LIMIT_RESET;
      hsize_r <= 7'd0;
      csize_r <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      hsize_r <= hsize_nxt;
      csize_r <= csize_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      if (cfg_we) begin
        case (cfg_idx)
          REG_HIT_THRESHOLD: thr_r <= cfg_wdata;
          REG_QUEUE_LIMIT: qlim_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    tail_r <= tail_nxt;
    head_r <= head_nxt;
    x_r <= x_nxt;
    cur_r <= cur_nxt;
    mem_r <= mem_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
    dsize_r <= dsize_nxt;
    res_r <= res_nxt;
    if (out_load) out_data_r <= out_d;
  end

`ifndef SYNTHESIS
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (hsize_r <= CAP7) && (csize_r <= CAP7))
    else $error("queue size above capacity");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> (!out_valid_r && !in_ready))
    else $error("activity during clearing pass");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("block idle right after taking an item");

  a_evict_head_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EV_WR) |-> ((head_r == HH) || (head_r == CH)))
    else $error("eviction from a non-head node");
`endif

endmodule
